>>> src/prrd_pkg.sv
// Package for the partitioned Rice residual decoder: request and result
// types, decoder phase codes and fixed field widths. No dependencies.
package prrd_pkg;

   // Decoder phases of the residual section.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CODING,
      PH_PORDER,
      PH_PARAM,
      PH_ESCW,
      PH_UNARY,
      PH_REMAIN,
      PH_RAW
   } phase_type;

   // Kind of a queued request, as sorted by the front end.
   typedef enum logic {
      ITEM_DATA,
      ITEM_START
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [16:0] block_size;
      logic [5:0]  predictor_order;
      logic [7:0]  data_byte;
   } req_item_type;

   // Head of the request queue as seen by the back end.
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [31:0] residual;
      logic        last;
      logic        error;
   } rsp_item_type;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   localparam logic [5:0] CODING_BITS      = 6'd2;
   localparam logic [5:0] PORDER_BITS      = 6'd4;
   localparam logic [5:0] PARAM_BITS_NARROW = 6'd4;
   localparam logic [5:0] PARAM_BITS_WIDE  = 6'd5;
   localparam logic [5:0] ESCW_BITS        = 6'd5;
   localparam logic [4:0] ESCAPE_NARROW    = 5'h0F;
   localparam logic [4:0] ESCAPE_WIDE      = 5'h1F;
   localparam logic [3:0] MAX_RESULTS      = 4'd8;
   localparam logic [4:0] BYTE_BITS        = 5'd8;

endpackage

>>> src/prrd_front.sv
// Front end of the residual decoder: takes requests, sorts them into start
// and data requests and holds them in a short queue. Uses prrd_pkg.
module prrd_front import prrd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [31:0]    req_tdata,
   input  logic           req_tuser,
   output queue_head_type head,
   input  logic           pop
);

   req_item_type                queue_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     count_ff, count_in;
   logic                        push;
   logic                        do_pop;
   req_item_type                new_item;

   assign req_tready = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != '0);

   always_comb begin
      new_item.kind            = req_tuser ? ITEM_START : ITEM_DATA;
      new_item.block_size      = req_tdata[16:0];
      new_item.predictor_order = req_tdata[22:17];
      new_item.data_byte       = req_tdata[30:23];
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_mem[rd_ptr_ff];

endmodule

>>> src/prrd_back.sv
// Back end of the residual decoder: bit-at-a-time section parser, Rice and
// escape sample decoding, and the result register. Uses prrd_pkg.
module prrd_back import prrd_pkg::*; #(
   parameter int RESIDUAL_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output rsp_item_type   rsp_item
);

   localparam logic [31:0] RES_MASK = 32'((64'd1 << RESIDUAL_BITS) - 64'd1);
   localparam logic [31:0] SAT_HI   = RES_MASK >> 1;
   localparam logic [31:0] SAT_LO   = ~SAT_HI;

   phase_type                phase_ff, phase_in;
   logic                     wide_ff, wide_in;
   logic [3:0]               porder_ff, porder_in;
   logic [15:0]              parts_left_ff, parts_left_in;
   logic [16:0]              samples_left_ff, samples_left_in;
   logic [4:0]               rice_ff, rice_in;
   logic [RESIDUAL_BITS-1:0] quot_ff, quot_in;
   logic [31:0]              accum_ff, accum_in;
   logic [5:0]               bits_needed_ff, bits_needed_in;
   logic [16:0]              size_ff, size_in;
   logic [5:0]               order_ff, order_in;
   logic [15:0]              pend_bits_ff, pend_bits_in;
   logic [4:0]               pend_count_ff, pend_count_in;
   logic                     busy_ff, busy_in;
   logic [3:0]               res_count_ff, res_count_in;
   logic                     out_valid_ff;
   rsp_item_type             out_item_ff;

   logic                     end_case, field_case, leave;
   logic                     emit, load, advance, out_free;
   logic                     end_part, go_idle;
   rsp_item_type             emit_item;

   logic [5:0]               part_bits;
   logic [16:0]              part_each, next_part_samples, samples_dec;
   logic [15:0]              parts_dec;
   logic [3:0]               new_porder;
   logic [16:0]              first_each, first_samples, porder_mask;
   logic                     porder_bad;
   logic [4:0]               bit_pos;
   logic                     cur_bit;
   logic [31:0]              unary_limit, rice_x, rice_value;
   logic                     rice_ovf;
   logic [31:0]              raw_mask, raw_u;
   logic [4:0]               raw_top;
   logic                     raw_sign;
   logic [31:0]              raw_value;
   logic [7:0]               keep_mask;

   // Shared partition arithmetic.
   assign part_bits         = wide_ff ? PARAM_BITS_WIDE : PARAM_BITS_NARROW;
   assign part_each         = size_ff >> porder_ff;
   assign next_part_samples = (porder_ff == '0) ? size_ff - 17'(order_ff) : part_each;
   assign parts_dec         = parts_left_ff - 1'b1;
   assign samples_dec       = samples_left_ff - 1'b1;

   // Partition order check on the freshly read field.
   assign new_porder    = accum_ff[3:0];
   assign first_each    = size_ff >> new_porder;
   assign first_samples = (new_porder == '0) ? size_ff - 17'(order_ff)
                                             : first_each - 17'(order_ff);
   assign porder_mask   = 17'((18'd1 << new_porder) - 18'd1);
   always_comb begin
      if (size_ff == '0) begin
         porder_bad = 1'b1;
      end else if (new_porder == '0) begin
         porder_bad = (size_ff <= 17'(order_ff));
      end else begin
         porder_bad = ((size_ff & porder_mask) != '0) || (first_each < 17'(order_ff));
      end
   end

   // Bit taken from the pending buffer.
   assign bit_pos = pend_count_ff - 1'b1;
   assign cur_bit = pend_bits_ff[bit_pos[3:0]];

   // Rice sample: the quotient is kept small enough that only an over-wide
   // remainder can overflow the residual range.
   assign unary_limit = RES_MASK >> rice_ff;
   assign rice_ovf    = (accum_ff & ~RES_MASK) != '0;
   assign rice_x      = (32'(quot_ff) << rice_ff) | accum_ff;
   assign rice_value  = {1'b0, rice_x[31:1]} ^ {32{rice_x[0]}};

   // Escape sample: sign extend from the raw width, then saturate.
   assign raw_mask  = (32'd1 << rice_ff) - 32'd1;
   assign raw_top   = rice_ff - 5'd1;
   assign raw_sign  = (rice_ff != '0) && accum_ff[raw_top];
   assign raw_u     = (rice_ff == '0) ? '0 : (raw_sign ? accum_ff | ~raw_mask : accum_ff);
   always_comb begin
      if ($signed(raw_u) > $signed(SAT_HI)) begin
         raw_value = SAT_HI;
      end else if ($signed(raw_u) < $signed(SAT_LO)) begin
         raw_value = SAT_LO;
      end else begin
         raw_value = raw_u;
      end
   end

   assign keep_mask = 8'((9'd1 << pend_count_ff[3:0]) - 9'd1);

   // Loop control: a request is finished once eight results have left, the
   // section has ended, or the next step needs a bit that is not there yet.
   assign end_case   = ((phase_ff == PH_UNARY) || (phase_ff == PH_RAW)) &&
                       (samples_left_ff == '0);
   assign field_case = (phase_ff != PH_UNARY) && (bits_needed_ff == '0);
   assign leave      = !busy_ff || (res_count_ff == MAX_RESULTS) || (phase_ff == PH_IDLE) ||
                       (!end_case && !field_case && (pend_count_ff == '0));

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance  = !emit || out_free;
   assign pop      = load && advance;

   always_comb begin
      phase_in        = phase_ff;
      wide_in         = wide_ff;
      porder_in       = porder_ff;
      parts_left_in   = parts_left_ff;
      samples_left_in = samples_left_ff;
      rice_in         = rice_ff;
      quot_in         = quot_ff;
      accum_in        = accum_ff;
      bits_needed_in  = bits_needed_ff;
      size_in         = size_ff;
      order_in        = order_ff;
      pend_bits_in    = pend_bits_ff;
      pend_count_in   = pend_count_ff;
      busy_in         = busy_ff;
      res_count_in    = res_count_ff;
      emit            = 1'b0;
      emit_item       = '0;
      load            = 1'b0;
      end_part        = 1'b0;
      go_idle         = 1'b0;

      if (!leave) begin
         if (end_case) begin
            end_part = 1'b1;
         end else if (field_case) begin
            case (phase_ff)
               PH_CODING: begin
                  if (accum_ff >= 32'd2) begin
                     emit      = 1'b1;
                     emit_item = '{residual: '0, last: 1'b1, error: 1'b1};
                     go_idle   = 1'b1;
                  end else begin
                     wide_in        = accum_ff[0];
                     phase_in       = PH_PORDER;
                     bits_needed_in = PORDER_BITS;
                     accum_in       = '0;
                  end
               end
               PH_PORDER: begin
                  porder_in = new_porder;
                  if (porder_bad) begin
                     emit      = 1'b1;
                     emit_item = '{residual: '0, last: 1'b1, error: 1'b1};
                     go_idle   = 1'b1;
                  end else begin
                     parts_left_in   = 16'd1 << new_porder;
                     phase_in        = PH_PARAM;
                     bits_needed_in  = part_bits;
                     accum_in        = '0;
                     samples_left_in = first_samples;
                  end
               end
               PH_PARAM: begin
                  rice_in = accum_ff[4:0];
                  if (accum_ff[4:0] == (wide_ff ? ESCAPE_WIDE : ESCAPE_NARROW)) begin
                     phase_in       = PH_ESCW;
                     bits_needed_in = ESCW_BITS;
                  end else begin
                     phase_in = PH_UNARY;
                     quot_in  = '0;
                  end
                  accum_in = '0;
               end
               PH_ESCW: begin
                  rice_in        = accum_ff[4:0];
                  phase_in       = PH_RAW;
                  bits_needed_in = 6'(accum_ff[4:0]);
                  accum_in       = '0;
               end
               PH_REMAIN: begin
                  if (rice_ovf) begin
                     emit      = 1'b1;
                     emit_item = '{residual: '0, last: 1'b1, error: 1'b1};
                     go_idle   = 1'b1;
                  end else begin
                     phase_in        = PH_UNARY;
                     quot_in         = '0;
                     accum_in        = '0;
                     emit            = 1'b1;
                     emit_item       = '{residual: rice_value,
                                         last: (samples_dec == '0) && (parts_left_ff == 16'd1),
                                         error: 1'b0};
                     samples_left_in = samples_dec;
                     end_part        = (samples_dec == '0);
                  end
               end
               PH_RAW: begin
                  bits_needed_in  = 6'(rice_ff);
                  accum_in        = '0;
                  emit            = 1'b1;
                  emit_item       = '{residual: raw_value,
                                      last: (samples_dec == '0) && (parts_left_ff == 16'd1),
                                      error: 1'b0};
                  samples_left_in = samples_dec;
                  end_part        = (samples_dec == '0);
               end
               default: begin
                  go_idle = 1'b1;
               end
            endcase
         end else begin
            pend_count_in = bit_pos;
            if (phase_ff == PH_UNARY) begin
               if (cur_bit) begin
                  phase_in       = PH_REMAIN;
                  bits_needed_in = 6'(rice_ff);
                  accum_in       = '0;
               end else if (32'(quot_ff) >= unary_limit) begin
                  emit      = 1'b1;
                  emit_item = '{residual: '0, last: 1'b1, error: 1'b1};
                  go_idle   = 1'b1;
               end else begin
                  quot_in = quot_ff + 1'b1;
               end
            end else begin
               accum_in       = {accum_ff[30:0], cur_bit};
               bits_needed_in = bits_needed_ff - 1'b1;
            end
         end
         if (emit) begin
            res_count_in = res_count_ff + 1'b1;
         end
      end else if (head.valid) begin
         load         = 1'b1;
         busy_in      = 1'b1;
         res_count_in = '0;
         if (head.item.kind == ITEM_START) begin
            phase_in        = PH_CODING;
            wide_in         = 1'b0;
            porder_in       = '0;
            parts_left_in   = '0;
            samples_left_in = '0;
            rice_in         = '0;
            quot_in         = '0;
            accum_in        = '0;
            bits_needed_in  = CODING_BITS;
            size_in         = head.item.block_size;
            order_in        = head.item.predictor_order;
            pend_bits_in    = {8'd0, head.item.data_byte};
            pend_count_in   = BYTE_BITS;
         end else if (phase_ff == PH_IDLE) begin
            // A data byte outside a section is dropped.
            busy_in = 1'b1;
         end else if (pend_count_ff > BYTE_BITS) begin
            emit         = 1'b1;
            emit_item    = '{residual: '0, last: 1'b1, error: 1'b1};
            go_idle      = 1'b1;
            res_count_in = 4'd1;
         end else begin
            pend_bits_in  = {pend_bits_ff[7:0] & keep_mask, head.item.data_byte};
            pend_count_in = pend_count_ff + BYTE_BITS;
         end
      end else begin
         busy_in = 1'b0;
      end

      if (end_part) begin
         parts_left_in = parts_dec;
         if (parts_dec == '0) begin
            go_idle = 1'b1;
         end else begin
            phase_in        = PH_PARAM;
            bits_needed_in  = part_bits;
            accum_in        = '0;
            samples_left_in = next_part_samples;
         end
      end
      if (go_idle) begin
         phase_in      = PH_IDLE;
         pend_bits_in  = '0;
         pend_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         wide_ff         <= 1'b0;
         porder_ff       <= '0;
         parts_left_ff   <= '0;
         samples_left_ff <= '0;
         rice_ff         <= '0;
         quot_ff         <= '0;
         accum_ff        <= '0;
         bits_needed_ff  <= '0;
         size_ff         <= '0;
         order_ff        <= '0;
         pend_bits_ff    <= '0;
         pend_count_ff   <= '0;
         busy_ff         <= 1'b0;
         res_count_ff    <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         wide_ff         <= wide_in;
         porder_ff       <= porder_in;
         parts_left_ff   <= parts_left_in;
         samples_left_ff <= samples_left_in;
         rice_ff         <= rice_in;
         quot_ff         <= quot_in;
         accum_ff        <= accum_in;
         bits_needed_ff  <= bits_needed_in;
         size_ff         <= size_in;
         order_ff        <= order_in;
         pend_bits_ff    <= pend_bits_in;
         pend_count_ff   <= pend_count_in;
         busy_ff         <= busy_in;
         res_count_ff    <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit && advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && advance) begin
         out_item_ff <= emit_item;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_item   = out_item_ff;

endmodule

>>> src/partitioned_rice_residual_decoder.sv
// Top level of the partitioned Rice residual decoder: joins the request
// queue front end and the decoding back end. Uses prrd_pkg.
//
// Usage. The request channel carries the residual section one byte per
// request, most significant bit first. A request with req_tuser high starts
// a new section: it latches the block size and predictor order and its own
// byte is the first byte of the section; a section in progress is dropped.
// Data requests outside a section are ignored. Each decoded residual leaves
// on the result channel; rsp_tlast marks the final residual of the section,
// and rsp_tuser marks an error result (residual zero, tlast high), after
// which the block waits for the next start request.
// Timing. Requests enter a four-deep queue, so the front end keeps taking
// them while the back end works. The back end loads a request, then works
// through it step by step: a stream bit, a completed field or a partition
// boundary; at most eight results leave per request. A backlog error result
// is emitted as its request loads. A full result register stalls the back
// end at its next result; the queue then fills and req_tready falls. Reset
// empties the queue and the result register and leaves the decoder idle.
module partitioned_rice_residual_decoder import prrd_pkg::*; #(
   parameter int RESIDUAL_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // block_size [16:0], predictor_order [22:17], data_byte [30:23], zero [31]
   input  logic [31:0] req_tdata,
   // start_req
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // residual [31:0], two's complement
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   // error
   output logic        rsp_tuser
);

   queue_head_type head;
   logic           pop;
   rsp_item_type   rsp_item;

   // Front end: request queue, sorting start requests from data requests.
   prrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   // Back end: section parser and sample decoder with its result register.
   prrd_back #(
      .RESIDUAL_BITS (RESIDUAL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = rsp_item.residual;
   assign rsp_tlast = rsp_item.last;
   assign rsp_tuser = rsp_item.error;

endmodule
